FILE: hw/rtl/tbt_pkg.sv
// Shared widths, constants and control structs for the per-triangle tangent block.
package tbt_pkg;

  localparam int POS_W  = 32;   // Q16.16 position
  localparam int TEX_W  = 16;   // Q4.12 texture coordinate
  localparam int NRM_W  = 16;   // Q1.14 normal
  localparam int OUT_W  = 16;   // Q1.14 result
  localparam int DT_W   = TEX_W + 1;   // texture delta
  localparam int E_W    = POS_W + 1;   // edge vector component
  localparam int MOP_W  = 34;          // multiplier operand
  localparam int ACC_W  = 2 * MOP_W;   // accumulator
  localparam int MAG_W  = 64;          // working magnitude
  localparam int SV_W   = 32;          // block-scaled component
  localparam int D_W    = 50;          // n.F dot product
  localparam int DL_W   = 24;          // low split of the dot product
  localparam int PV_W   = 42;          // projected component
  localparam int RND_SH = 28;          // projection scale
  localparam int LEN_W  = 32;          // vector length
  localparam int FRAC_W = 14;          // output fraction bits
  localparam int Q_W    = FRAC_W + 1;  // quotient bits
  localparam int NUM_W  = LEN_W + FRAC_W;
  localparam int CNT_W  = 6;
  localparam int ROOT_STEPS = MAG_W / 2;
  localparam logic [1:0] SLOT_LAST = 2'd2;

  typedef struct packed {
    logic en;
    logic clr;
    logic neg;
    logic sh;
  } mac_ctl_t;

  typedef struct packed {
    logic start_root;
    logic start_div;
  } sd_cmd_t;

endpackage

FILE: hw/rtl/tbt_mac.sv
// Shared signed multiply-accumulate unit.
module tbt_mac (
  input  logic                                clk,
  input  tbt_pkg::mac_ctl_t                   ctl,
  input  logic signed [tbt_pkg::MOP_W-1:0]    op_a,
  input  logic signed [tbt_pkg::MOP_W-1:0]    op_b,
  output logic signed [tbt_pkg::ACC_W-1:0]    acc
);

  logic signed [tbt_pkg::ACC_W-1:0] prod;
  logic signed [tbt_pkg::ACC_W-1:0] term;
  logic signed [tbt_pkg::ACC_W-1:0] base;
  logic signed [tbt_pkg::ACC_W-1:0] acc_r;

  assign prod = op_a * op_b;

  always_comb begin
    term = ctl.sh ? (prod <<< tbt_pkg::DL_W) : prod;
    if (ctl.neg) begin
      term = -term;
    end
    base = ctl.clr ? '0 : acc_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= base + term;
    end
  end

  assign acc = acc_r;

endmodule

FILE: hw/rtl/tbt_sqdiv.sv
// Iterative square root (two bits a step) and restoring divider (one bit a step).
module tbt_sqdiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tbt_pkg::sd_cmd_t              cmd,
  input  logic [tbt_pkg::MAG_W-1:0]     rad,
  input  logic [tbt_pkg::LEN_W-1:0]     num_m,
  output logic                          busy,
  output logic [tbt_pkg::Q_W-1:0]       quo
);

  logic [tbt_pkg::MAG_W-1:0] x_r, r_r, b_r;
  logic [tbt_pkg::MAG_W-1:0] rb;
  logic                      root_ge;
  logic [tbt_pkg::CNT_W-1:0] cnt_r;
  logic                      div_r;
  logic [tbt_pkg::LEN_W-1:0] rem_r;
  logic [tbt_pkg::Q_W-1:0]   nlo_r, q_r;
  logic [tbt_pkg::NUM_W-1:0] num;
  logic [tbt_pkg::LEN_W:0]   trial, lenx, diff;
  logic                      div_ge;

  always_comb begin
    rb      = r_r + b_r;
    root_ge = x_r >= rb;
    // divisor is the root left in r_r
    num     = {num_m, {tbt_pkg::FRAC_W{1'b0}}}
              + tbt_pkg::NUM_W'(r_r[tbt_pkg::LEN_W-1:0] >> 1);
    trial   = {rem_r, nlo_r[tbt_pkg::Q_W-1]};
    lenx    = {1'b0, r_r[tbt_pkg::LEN_W-1:0]};
    div_ge  = trial >= lenx;
    diff    = trial - lenx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      div_r <= 1'b0;
    end else if (cmd.start_root) begin
      cnt_r <= tbt_pkg::CNT_W'(tbt_pkg::ROOT_STEPS);
      div_r <= 1'b0;
    end else if (cmd.start_div) begin
      cnt_r <= tbt_pkg::CNT_W'(tbt_pkg::Q_W);
      div_r <= 1'b1;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_root) begin
      x_r <= rad;
      r_r <= '0;
      b_r <= tbt_pkg::MAG_W'(1) << (tbt_pkg::MAG_W - 2);
    end else if (cmd.start_div) begin
      rem_r <= tbt_pkg::LEN_W'(num[tbt_pkg::NUM_W-1:tbt_pkg::Q_W]);
      nlo_r <= num[tbt_pkg::Q_W-1:0];
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      if (div_r) begin
        rem_r <= div_ge ? diff[tbt_pkg::LEN_W-1:0] : trial[tbt_pkg::LEN_W-1:0];
        nlo_r <= nlo_r << 1;
        q_r   <= {q_r[tbt_pkg::Q_W-2:0], div_ge};
      end else begin
        if (root_ge) begin
          x_r <= x_r - rb;
          r_r <= (r_r >> 1) + b_r;
        end else begin
          r_r <= r_r >> 1;
        end
        b_r <= b_r >> 2;
      end
    end
  end

  assign busy = (cnt_r != '0);
  assign quo  = q_r;

endmodule

FILE: hw/rtl/tangent_bitangent_per_triangle.sv
// Per-triangle tangent/bitangent top level: vertex capture, sequencer and result register.
// Vertices 0 and 1 are only captured and give no result; the third stalls the input while
// the sequencer runs the determinant, face vectors and face scaling, then per vector the
// dot, projection, scaling, squares, root and divide, for six vectors (a degenerate vector
// skips its later steps), with each result loaded into a one-deep output register.
// rst_n (synchronous, active low) clears the sequencer, vertex slot and output valid.
module tangent_bitangent_per_triangle (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [tbt_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [tbt_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [tbt_pkg::POS_W-1:0]   in_pos_z,
  input  logic signed [tbt_pkg::TEX_W-1:0]   in_tex_u,
  input  logic signed [tbt_pkg::TEX_W-1:0]   in_tex_v,
  input  logic signed [tbt_pkg::NRM_W-1:0]   in_norm_x,
  input  logic signed [tbt_pkg::NRM_W-1:0]   in_norm_y,
  input  logic signed [tbt_pkg::NRM_W-1:0]   in_norm_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tbt_pkg::OUT_W-1:0]   out_tan_x,
  output logic signed [tbt_pkg::OUT_W-1:0]   out_tan_y,
  output logic signed [tbt_pkg::OUT_W-1:0]   out_tan_z,
  output logic signed [tbt_pkg::OUT_W-1:0]   out_bit_x,
  output logic signed [tbt_pkg::OUT_W-1:0]   out_bit_y,
  output logic signed [tbt_pkg::OUT_W-1:0]   out_bit_z,
  output logic                               out_degenerate,
  output logic                               out_last
);

  // Sequencer states. DET/FACE build the face vectors, SCALE normalizes a
  // vector's exponent one bit per cycle, DOT..DIV make one unit vector.
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_DET   = 10'b00_0000_0010,
    S_FACE  = 10'b00_0000_0100,
    S_SCALE = 10'b00_0000_1000,
    S_DOT   = 10'b00_0001_0000,
    S_PROJ  = 10'b00_0010_0000,
    S_SQ    = 10'b00_0100_0000,
    S_ROOT  = 10'b00_1000_0000,
    S_DIV   = 10'b01_0000_0000,
    S_EMIT  = 10'b10_0000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [1:0] idx_r, idx_nxt, idx_c, div_sel;
  logic       vec_r, vec_nxt;
  logic [1:0] vtx_r, vtx_nxt;
  logic       face_r, face_nxt;
  logic       vec_end;

  // held vertices and triangle setup
  logic signed [tbt_pkg::POS_W-1:0] p0_r [3];
  logic signed [tbt_pkg::POS_W-1:0] p1_r [3];
  logic signed [tbt_pkg::TEX_W-1:0] t0u_r, t0v_r, t1u_r, t1v_r;
  logic signed [tbt_pkg::NRM_W-1:0] nrm_r [3][3];
  logic signed [tbt_pkg::DT_W-1:0]  du1_r, dv1_r, du2_r, dv2_r;
  logic signed [tbt_pkg::E_W-1:0]   e1_r [3];
  logic signed [tbt_pkg::E_W-1:0]   e2_r [3];
  logic                             det_neg_r, det_nz_r;

  // working vector (sign/magnitude) and results
  logic [tbt_pkg::MAG_W-1:0]        wm_r [3];
  logic                             ws_r [3];
  logic signed [tbt_pkg::SV_W-1:0]  sv_r [2][3];
  logic                             fok_r [2];
  logic signed [tbt_pkg::D_W-1:0]   d_r;
  logic signed [tbt_pkg::OUT_W-1:0] res_r [2][3];
  logic                             bad_r [2];

  // output register
  logic                             out_valid_r;
  logic                             out_load;
  logic signed [tbt_pkg::OUT_W-1:0] out_tan_r [3];
  logic signed [tbt_pkg::OUT_W-1:0] out_bit_r [3];
  logic                             out_deg_r, out_last_r;

  // shared units
  tbt_pkg::mac_ctl_t                mac_ctl;
  logic signed [tbt_pkg::MOP_W-1:0] mac_a, mac_b;
  logic signed [tbt_pkg::ACC_W-1:0] mac_acc;
  tbt_pkg::sd_cmd_t                 sd_cmd;
  logic                             sd_busy;
  logic [tbt_pkg::Q_W-1:0]          sd_quo;

  // datapath helpers
  logic                             acc_neg;
  logic [tbt_pkg::ACC_W-1:0]        acc_mag, rsum;
  logic signed [tbt_pkg::PV_W-1:0]  rv, pv, pmag;
  logic signed [tbt_pkg::SV_W-1:0]  fsel;
  logic                             sc_zero, sc_big, sc_small, sc_done;
  logic signed [tbt_pkg::SV_W-1:0]  sc_val [3];
  logic signed [tbt_pkg::OUT_W-1:0] qs;
  logic signed [tbt_pkg::MOP_W-1:0] dh_ext, dl_ext;

  assign in_stall = (state_r != S_IDLE);
  assign idx_c    = (idx_r == 2'd3) ? 2'd0 : idx_r;
  assign div_sel  = (idx_nxt == 2'd3) ? 2'd0 : idx_nxt;

  tbt_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (mac_acc)
  );

  tbt_sqdiv u_sqdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (sd_cmd),
    .rad   (mac_acc[tbt_pkg::MAG_W-1:0]),
    .num_m (wm_r[div_sel][tbt_pkg::LEN_W-1:0]),
    .busy  (sd_busy),
    .quo   (sd_quo)
  );

  // Exponent search over the working vector and projection rounding.
  always_comb begin
    sc_zero  = (wm_r[0] == '0) && (wm_r[1] == '0) && (wm_r[2] == '0);
    sc_big   = (|wm_r[0][tbt_pkg::MAG_W-1:tbt_pkg::SV_W-1])
             | (|wm_r[1][tbt_pkg::MAG_W-1:tbt_pkg::SV_W-1])
             | (|wm_r[2][tbt_pkg::MAG_W-1:tbt_pkg::SV_W-1]);
    sc_small = !((|wm_r[0][tbt_pkg::MAG_W-1:tbt_pkg::SV_W-2])
               | (|wm_r[1][tbt_pkg::MAG_W-1:tbt_pkg::SV_W-2])
               | (|wm_r[2][tbt_pkg::MAG_W-1:tbt_pkg::SV_W-2]));
    sc_done  = sc_zero || (!sc_big && !sc_small);
    for (int i = 0; i < 3; i++) begin
      sc_val[i] = ws_r[i] ? -$signed(wm_r[i][tbt_pkg::SV_W-1:0])
                          : $signed(wm_r[i][tbt_pkg::SV_W-1:0]);
    end
    acc_neg = mac_acc[tbt_pkg::ACC_W-1];
    acc_mag = acc_neg ? -mac_acc : mac_acc;
    // round half away from zero on the magnitude
    rsum    = acc_mag + (tbt_pkg::ACC_W'(1) << (tbt_pkg::RND_SH - 1));
    rv      = {1'b0, rsum[tbt_pkg::RND_SH +: tbt_pkg::PV_W-1]};
    fsel    = sv_r[vec_r][idx_c];
    pv      = acc_neg ? (tbt_pkg::PV_W'(fsel) + rv) : (tbt_pkg::PV_W'(fsel) - rv);
    pmag    = pv[tbt_pkg::PV_W-1] ? -pv : pv;
    qs      = $signed({1'b0, sd_quo});
    dh_ext  = tbt_pkg::MOP_W'($signed(d_r[tbt_pkg::D_W-1:tbt_pkg::DL_W]));
    dl_ext  = {{(tbt_pkg::MOP_W-tbt_pkg::DL_W){1'b0}}, d_r[tbt_pkg::DL_W-1:0]};
  end

  // Operand selection for the shared multiply-accumulate.
  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    unique case (state_r)
      S_DET: begin
        mac_ctl.en  = (ph_r != 2'd2);
        mac_ctl.clr = (ph_r == 2'd0);
        mac_ctl.neg = (ph_r == 2'd1);
        mac_a = (ph_r == 2'd0) ? tbt_pkg::MOP_W'(du1_r) : tbt_pkg::MOP_W'(dv1_r);
        mac_b = (ph_r == 2'd0) ? tbt_pkg::MOP_W'(dv2_r) : tbt_pkg::MOP_W'(du2_r);
      end
      S_FACE: begin
        mac_ctl.en  = (ph_r != 2'd2);
        mac_ctl.clr = (ph_r == 2'd0);
        mac_ctl.neg = (ph_r == 2'd1);
        if (!vec_r) begin
          // tangent: dv2*e1 - dv1*e2
          mac_a = (ph_r == 2'd0) ? tbt_pkg::MOP_W'(dv2_r) : tbt_pkg::MOP_W'(dv1_r);
          mac_b = (ph_r == 2'd0) ? tbt_pkg::MOP_W'(e1_r[idx_c])
                                 : tbt_pkg::MOP_W'(e2_r[idx_c]);
        end else begin
          // bitangent: du1*e2 - du2*e1
          mac_a = (ph_r == 2'd0) ? tbt_pkg::MOP_W'(du1_r) : tbt_pkg::MOP_W'(du2_r);
          mac_b = (ph_r == 2'd0) ? tbt_pkg::MOP_W'(e2_r[idx_c])
                                 : tbt_pkg::MOP_W'(e1_r[idx_c]);
        end
      end
      S_DOT: begin
        mac_ctl.en  = (idx_r != 2'd3);
        mac_ctl.clr = (idx_r == 2'd0);
        mac_a = tbt_pkg::MOP_W'(nrm_r[vtx_r][idx_c]);
        mac_b = tbt_pkg::MOP_W'(sv_r[vec_r][idx_c]);
      end
      S_PROJ: begin
        // n_i*d split as n_i*d_hi<<24 + n_i*d_lo
        mac_ctl.en  = (ph_r != 2'd2);
        mac_ctl.clr = (ph_r == 2'd0);
        mac_ctl.sh  = (ph_r == 2'd0);
        mac_a = tbt_pkg::MOP_W'(nrm_r[vtx_r][idx_c]);
        mac_b = (ph_r == 2'd0) ? dh_ext : dl_ext;
      end
      S_SQ: begin
        mac_ctl.en  = (idx_r != 2'd3);
        mac_ctl.clr = (idx_r == 2'd0);
        mac_a = $signed(wm_r[idx_c][tbt_pkg::MOP_W-1:0]);
        mac_b = $signed(wm_r[idx_c][tbt_pkg::MOP_W-1:0]);
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    ph_nxt    = ph_r;
    idx_nxt   = idx_r;
    vec_nxt   = vec_r;
    vtx_nxt   = vtx_r;
    face_nxt  = face_r;
    sd_cmd    = '0;
    vec_end   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (slot_r == tbt_pkg::SLOT_LAST) begin
            slot_nxt  = 2'd0;
            ph_nxt    = 2'd0;
            state_nxt = S_DET;
          end else begin
            slot_nxt = slot_r + 2'd1;
          end
        end
      end
      S_DET: begin
        ph_nxt = ph_r + 2'd1;
        if (ph_r == 2'd2) begin
          ph_nxt    = 2'd0;
          idx_nxt   = 2'd0;
          vec_nxt   = 1'b0;
          state_nxt = S_FACE;
        end
      end
      S_FACE: begin
        ph_nxt = ph_r + 2'd1;
        if (ph_r == 2'd2) begin
          ph_nxt  = 2'd0;
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd2) begin
            idx_nxt   = 2'd0;
            face_nxt  = 1'b1;
            state_nxt = S_SCALE;
          end
        end
      end
      S_SCALE: begin
        if (sc_done) begin
          if (face_r) begin
            if (!vec_r) begin
              vec_nxt   = 1'b1;
              state_nxt = S_FACE;
            end else begin
              vec_nxt   = 1'b0;
              vtx_nxt   = 2'd0;
              state_nxt = S_DOT;
            end
          end else if (sc_zero) begin
            vec_end = 1'b1;
          end else begin
            state_nxt = S_SQ;
          end
        end
      end
      S_DOT: begin
        if (idx_r == 2'd0 && !fok_r[vec_r]) begin
          vec_end = 1'b1;
        end else if (idx_r == 2'd3) begin
          idx_nxt   = 2'd0;
          ph_nxt    = 2'd0;
          state_nxt = S_PROJ;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      S_PROJ: begin
        ph_nxt = ph_r + 2'd1;
        if (ph_r == 2'd2) begin
          ph_nxt  = 2'd0;
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd2) begin
            idx_nxt   = 2'd0;
            face_nxt  = 1'b0;
            state_nxt = S_SCALE;
          end
        end
      end
      S_SQ: begin
        if (idx_r == 2'd3) begin
          idx_nxt           = 2'd0;
          sd_cmd.start_root = 1'b1;
          state_nxt         = S_ROOT;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      S_ROOT: begin
        if (!sd_busy) begin
          sd_cmd.start_div = 1'b1;
          state_nxt        = S_DIV;
        end
      end
      S_DIV: begin
        if (!sd_busy) begin
          if (idx_r == 2'd2) begin
            vec_end = 1'b1;
          end else begin
            idx_nxt          = idx_r + 2'd1;
            sd_cmd.start_div = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          if (vtx_r == 2'd2) begin
            state_nxt = S_IDLE;
          end else begin
            vtx_nxt   = vtx_r + 2'd1;
            vec_nxt   = 1'b0;
            idx_nxt   = 2'd0;
            state_nxt = S_DOT;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // one vector finished: bitangent next, or hand the vertex to the output
    if (vec_end) begin
      idx_nxt = 2'd0;
      if (!vec_r) begin
        vec_nxt   = 1'b1;
        state_nxt = S_DOT;
      end else begin
        state_nxt = S_EMIT;
      end
    end
  end

  assign out_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= 2'd0;
      ph_r        <= 2'd0;
      idx_r       <= 2'd0;
      vec_r       <= 1'b0;
      vtx_r       <= 2'd0;
      face_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      ph_r        <= ph_nxt;
      idx_r       <= idx_nxt;
      vec_r       <= vec_nxt;
      vtx_r       <= vtx_nxt;
      face_r      <= face_nxt;
      out_valid_r <= out_load | (out_valid_r & out_stall);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      if (slot_r == tbt_pkg::SLOT_LAST) begin
        // third vertex: form deltas, keep only its normal
        du1_r <= tbt_pkg::DT_W'(t1u_r) - tbt_pkg::DT_W'(t0u_r);
        dv1_r <= tbt_pkg::DT_W'(t1v_r) - tbt_pkg::DT_W'(t0v_r);
        du2_r <= tbt_pkg::DT_W'(in_tex_u) - tbt_pkg::DT_W'(t0u_r);
        dv2_r <= tbt_pkg::DT_W'(in_tex_v) - tbt_pkg::DT_W'(t0v_r);
        for (int i = 0; i < 3; i++) begin
          e1_r[i] <= tbt_pkg::E_W'(p1_r[i]) - tbt_pkg::E_W'(p0_r[i]);
        end
        e2_r[0] <= tbt_pkg::E_W'(in_pos_x) - tbt_pkg::E_W'(p0_r[0]);
        e2_r[1] <= tbt_pkg::E_W'(in_pos_y) - tbt_pkg::E_W'(p0_r[1]);
        e2_r[2] <= tbt_pkg::E_W'(in_pos_z) - tbt_pkg::E_W'(p0_r[2]);
        nrm_r[2][0] <= in_norm_x;
        nrm_r[2][1] <= in_norm_y;
        nrm_r[2][2] <= in_norm_z;
      end else if (!slot_r[0]) begin
        p0_r[0] <= in_pos_x;
        p0_r[1] <= in_pos_y;
        p0_r[2] <= in_pos_z;
        t0u_r   <= in_tex_u;
        t0v_r   <= in_tex_v;
        nrm_r[0][0] <= in_norm_x;
        nrm_r[0][1] <= in_norm_y;
        nrm_r[0][2] <= in_norm_z;
      end else begin
        p1_r[0] <= in_pos_x;
        p1_r[1] <= in_pos_y;
        p1_r[2] <= in_pos_z;
        t1u_r   <= in_tex_u;
        t1v_r   <= in_tex_v;
        nrm_r[1][0] <= in_norm_x;
        nrm_r[1][1] <= in_norm_y;
        nrm_r[1][2] <= in_norm_z;
      end
    end

    if (state_r == S_DET && ph_r == 2'd2) begin
      det_neg_r <= acc_neg;
      det_nz_r  <= (mac_acc != '0);
    end

    if (state_r == S_FACE && ph_r == 2'd2) begin
      wm_r[idx_c] <= acc_mag[tbt_pkg::MAG_W-1:0];
      ws_r[idx_c] <= acc_neg ^ det_neg_r;
    end

    if (state_r == S_SCALE) begin
      if (!sc_done) begin
        for (int i = 0; i < 3; i++) begin
          wm_r[i] <= sc_big ? (wm_r[i] >> 1) : (wm_r[i] << 1);
        end
      end else if (face_r) begin
        for (int i = 0; i < 3; i++) begin
          sv_r[vec_r][i] <= sc_val[i];
        end
        fok_r[vec_r] <= !sc_zero && det_nz_r;
      end else if (sc_zero) begin
        for (int i = 0; i < 3; i++) begin
          res_r[vec_r][i] <= '0;
        end
        bad_r[vec_r] <= 1'b1;
      end
    end

    if (state_r == S_DOT) begin
      if (idx_r == 2'd0 && !fok_r[vec_r]) begin
        for (int i = 0; i < 3; i++) begin
          res_r[vec_r][i] <= '0;
        end
        bad_r[vec_r] <= 1'b1;
      end else if (idx_r == 2'd3) begin
        d_r <= mac_acc[tbt_pkg::D_W-1:0];
      end
    end

    if (state_r == S_PROJ && ph_r == 2'd2) begin
      wm_r[idx_c] <= {{(tbt_pkg::MAG_W-tbt_pkg::PV_W){1'b0}}, pmag};
      ws_r[idx_c] <= pv[tbt_pkg::PV_W-1];
    end

    if (state_r == S_DIV && !sd_busy) begin
      res_r[vec_r][idx_c] <= ws_r[idx_c] ? -qs : qs;
      if (idx_r == 2'd2) begin
        bad_r[vec_r] <= 1'b0;
      end
    end

    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        out_tan_r[i] <= res_r[0][i];
        out_bit_r[i] <= res_r[1][i];
      end
      out_deg_r  <= bad_r[0] | bad_r[1];
      out_last_r <= (vtx_r == 2'd2);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tan_x      = out_tan_r[0];
  assign out_tan_y      = out_tan_r[1];
  assign out_tan_z      = out_tan_r[2];
  assign out_bit_x      = out_bit_r[0];
  assign out_bit_y      = out_bit_r[1];
  assign out_bit_z      = out_bit_r[2];
  assign out_degenerate = out_deg_r;
  assign out_last       = out_last_r;

endmodule
